// ===== rtl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// types, codes and pipeline depths shared by the mesh vertex transform
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

    // input item
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [31:0]        tex_u;
        logic [31:0]        tex_v;
        logic [23:0]        corner_a;
        logic [23:0]        corner_b;
        logic [23:0]        corner_c;
    } t_in;

    // result item
    typedef struct packed {
        logic [1:0]         out_kind;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_norm_x;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_z;
        logic [31:0]        out_u;
        logic [31:0]        out_v;
        logic [23:0]        out_first;
        logic [23:0]        out_second;
        logic [23:0]        out_third;
    } t_out;

    // item data that rides alongside the normal pipeline
    typedef struct packed {
        logic        req_type;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic        tri_ovf;
        logic [23:0] first;
        logic [23:0] second;
        logic [23:0] third;
    } t_side;

    // normal unit result
    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               zero;
    } t_nrm;

    localparam logic       REQ_TRI     = 1'b1;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_OVF    = 2'd3;

    localparam logic [2:0] REG_TRANS_X    = 3'd0;
    localparam logic [2:0] REG_TRANS_Y    = 3'd1;
    localparam logic [2:0] REG_TRANS_Z    = 3'd2;
    localparam logic [2:0] REG_ROTATION   = 3'd3;
    localparam logic [2:0] REG_SCALE_X    = 3'd4;
    localparam logic [2:0] REG_SCALE_Y    = 3'd5;
    localparam logic [2:0] REG_SCALE_Z    = 3'd6;
    localparam logic [2:0] REG_INDEX_BASE = 3'd7;

    localparam logic [31:0] ROT_RESET   = 32'h4000_0000;
    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

    // squared length at or below which a normal counts as zero
    localparam logic [41:0] NEAR_ZERO_SQ = 42'd1934281311;

    // divider and root sizes
    localparam int DIV1_QW = 46;
    localparam int SQRT_RW = 21;
    localparam int DIV2_QW = 15;

    // stage counts
    localparam int POS_LAT  = 6;
    localparam int NORM_LAT = 1 + (DIV1_QW + 1) + 2 + 1 + 2 + 1 + 1 + 1 + SQRT_RW + 1
                            + (DIV2_QW + 1);

endpackage

`default_nettype wire

// ===== rtl/mvt_delay.sv =====
// ----------------------------------------------------------------------------
// mvt_delay
// enabled shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [WIDTH-1:0]  i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int j = 1; j < DEPTH; j++) begin
                r_pipe[j] <= r_pipe[j-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/mvt_div.sv =====
// ----------------------------------------------------------------------------
// mvt_div
// pipelined restoring divider, one quotient bit per stage, signed result
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 21,
    parameter int QUO_W = 15,
    parameter int OUT_W = 16
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire  [NUM_W-1:0]        i_num,
    input  wire  [DEN_W-1:0]        i_den,
    input  wire                     i_neg,
    output logic signed [OUT_W-1:0] o_quo
);

    // the high part of the dividend must be below the divisor

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_qd  [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic             r_neg [QUO_W];
    logic [DEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_qd  [QUO_W];
    logic [DEN_W-1:0] n_den [QUO_W];
    logic             n_neg [QUO_W];

    logic signed [OUT_W-1:0] r_quo;
    logic signed [OUT_W-1:0] n_quo;
    logic signed [OUT_W-1:0] quo_mag;

    always_comb begin
        logic [DEN_W-1:0] rem_s;
        logic [QUO_W-1:0] qd_s;
        logic [DEN_W-1:0] den_s;
        logic             neg_s;
        logic [DEN_W:0]   trial;
        logic             ge;
        for (int j = 0; j < QUO_W; j++) begin
            if (j == 0) begin
                rem_s = DEN_W'(i_num[NUM_W-1:QUO_W]);
                qd_s  = i_num[QUO_W-1:0];
                den_s = i_den;
                neg_s = i_neg;
            end else begin
                rem_s = r_rem[j-1];
                qd_s  = r_qd[j-1];
                den_s = r_den[j-1];
                neg_s = r_neg[j-1];
            end
            trial    = {rem_s, qd_s[QUO_W-1]};
            ge       = (trial >= {1'b0, den_s});
            n_rem[j] = ge ? DEN_W'(trial - {1'b0, den_s}) : trial[DEN_W-1:0];
            n_qd[j]  = {qd_s[QUO_W-2:0], ge};
            n_den[j] = den_s;
            n_neg[j] = neg_s;
        end
    end

    assign quo_mag = OUT_W'({1'b0, r_qd[QUO_W-1]});
    assign n_quo   = r_neg[QUO_W-1] ? -quo_mag : quo_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QUO_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_qd[j]  <= n_qd[j];
                r_den[j] <= n_den[j];
                r_neg[j] <= n_neg[j];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

// ===== rtl/mvt_sqrt.sv =====
// ----------------------------------------------------------------------------
// mvt_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_sqrt #(
    parameter int ROOT_W = 21
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire  [2*ROOT_W-1:0] i_x,
    output logic [ROOT_W-1:0]   o_root
);

    logic [ROOT_W+1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [2*ROOT_W-1:0] r_x    [ROOT_W];
    logic [ROOT_W+1:0]   n_rem  [ROOT_W];
    logic [ROOT_W-1:0]   n_root [ROOT_W];
    logic [2*ROOT_W-1:0] n_x    [ROOT_W];

    always_comb begin
        logic [ROOT_W+1:0]   rem_s;
        logic [ROOT_W-1:0]   root_s;
        logic [2*ROOT_W-1:0] x_s;
        logic [ROOT_W+3:0]   t;
        logic [ROOT_W+3:0]   trial;
        logic                ge;
        for (int j = 0; j < ROOT_W; j++) begin
            if (j == 0) begin
                rem_s  = '0;
                root_s = '0;
                x_s    = i_x;
            end else begin
                rem_s  = r_rem[j-1];
                root_s = r_root[j-1];
                x_s    = r_x[j-1];
            end
            t         = {rem_s, x_s[2*ROOT_W-1:2*ROOT_W-2]};
            trial     = (ROOT_W+4)'({root_s, 2'b01});
            ge        = (t >= trial);
            n_rem[j]  = ge ? (ROOT_W+2)'(t - trial) : t[ROOT_W+1:0];
            n_root[j] = {root_s[ROOT_W-2:0], ge};
            n_x[j]    = {x_s[2*ROOT_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < ROOT_W; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_x[j]    <= n_x[j];
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/mvt_norm.sv =====
// ----------------------------------------------------------------------------
// mvt_norm
// normal path: inverse scale, yaw rotation and renormalization to unit length
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_norm (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire signed [15:0] i_norm_x,
    input  wire signed [15:0] i_norm_y,
    input  wire signed [15:0] i_norm_z,
    input  wire signed [31:0] i_scale_x,
    input  wire signed [31:0] i_scale_y,
    input  wire signed [31:0] i_scale_z,
    input  wire signed [15:0] i_cos,
    input  wire signed [15:0] i_sin,
    output mvt_pkg::t_nrm     o_res
);

    localparam int QW1 = mvt_pkg::DIV1_QW;
    localparam int RW  = mvt_pkg::SQRT_RW;
    localparam int QW2 = mvt_pkg::DIV2_QW;
    localparam int SIDE_W = 3 * RW + 3 + 1;

    logic signed [15:0] norm_in  [3];
    logic signed [31:0] scale_in [3];

    assign norm_in[0]  = i_norm_x;
    assign norm_in[1]  = i_norm_y;
    assign norm_in[2]  = i_norm_z;
    assign scale_in[0] = i_scale_x;
    assign scale_in[1] = i_scale_y;
    assign scale_in[2] = i_scale_z;

    // magnitudes and result sign for the inverse scale
    logic [15:0] r_nmag [3];
    logic [31:0] r_smag [3];
    logic        r_dneg [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_nmag[a] <= norm_in[a][15] ? 16'(-norm_in[a]) : 16'(norm_in[a]);
                r_smag[a] <= scale_in[a][31] ? 32'(-scale_in[a]) : 32'(scale_in[a]);
                r_dneg[a] <= norm_in[a][15] ^ scale_in[a][31];
            end
        end
    end

    // norm * 2^30 / scale, truncated toward zero
    logic signed [QW1:0] inv [3];

    for (genvar a = 0; a < 3; a++) begin : g_div1
        mvt_div #(
            .NUM_W (QW1 + 1),
            .DEN_W (32),
            .QUO_W (QW1),
            .OUT_W (QW1 + 1)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num ({1'b0, r_nmag[a], 30'd0}),
            .i_den (r_smag[a]),
            .i_neg (r_dneg[a]),
            .o_quo (inv[a])
        );
    end

    // yaw rotation: products, then sums
    logic signed [62:0] r_cx, r_sz, r_cz, r_sx;
    logic signed [QW1:0] r_iy;
    logic signed [63:0] r_v [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= 63'(i_cos) * 63'(inv[0]);
            r_sz <= 63'(i_sin) * 63'(inv[2]);
            r_cz <= 63'(i_cos) * 63'(inv[2]);
            r_sx <= 63'(i_sin) * 63'(inv[0]);
            r_iy <= inv[1];
            r_v[0] <= 64'(r_cx) + 64'(r_sz);
            r_v[1] <= 64'(r_iy) <<< 14;
            r_v[2] <= 64'(r_cz) - 64'(r_sx);
        end
    end

    // shift search: magnitudes, byte leading-one, then shift count
    logic signed [63:0] r_va [3];
    logic [63:0]        r_abs [3];
    logic signed [63:0] r_vb [3];
    logic [7:0]         r_gnz;
    logic [3:0]         r_glen [8];
    logic signed [63:0] r_vc [3];
    logic [5:0]         r_k;
    logic [63:0]        mag_or;
    logic [3:0]         n_glen [8];
    logic [5:0]         n_k;

    assign mag_or = r_abs[0] | r_abs[1] | r_abs[2];

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n_glen[g] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                if (mag_or[8*g+b]) begin
                    n_glen[g] = 4'(b + 1);
                end
            end
        end
    end

    always_comb begin
        logic [6:0] blen;
        blen = 7'd0;
        for (int g = 0; g < 8; g++) begin
            if (r_gnz[g]) begin
                blen = 7'(8 * g) + 7'(r_glen[g]);
            end
        end
        n_k = (blen > 7'd20) ? 6'(blen - 7'd20) : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_va[a]  <= r_v[a];
                r_abs[a] <= r_v[a][63] ? 64'(-r_v[a]) : 64'(r_v[a]);
                r_vb[a]  <= r_va[a];
                r_vc[a]  <= r_vb[a];
            end
            for (int g = 0; g < 8; g++) begin
                r_gnz[g]  <= |mag_or[8*g +: 8];
                r_glen[g] <= n_glen[g];
            end
            r_k <= n_k;
        end
    end

    // shifted vector, squares, sum of squares
    logic signed [RW-1:0] r_w [3];
    logic [5:0]           r_k4, r_k5;
    logic [41:0]          r_sq [3];
    logic [RW-1:0]        r_aw [3];
    logic [2:0]           r_sgn;
    logic signed [41:0]   sq [3];
    logic [41:0]          r_s;
    logic [SIDE_W-1:0]    r_side;
    logic [SIDE_W-1:0]    side_d;

    for (genvar a = 0; a < 3; a++) begin : g_sq
        assign sq[a] = 42'(r_w[a]) * 42'(r_w[a]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_w[a]  <= RW'(r_vc[a] >>> r_k);
                r_sq[a] <= sq[a];
                r_aw[a] <= r_w[a][RW-1] ? RW'(-r_w[a]) : RW'(r_w[a]);
                r_sgn[a] <= r_w[a][RW-1];
            end
            r_k4 <= r_k;
            r_k5 <= r_k4;
            r_s  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side <= {r_aw[0], r_aw[1], r_aw[2], r_sgn,
                       (r_k5 == 6'd0) &&
                       ((r_sq[0] + r_sq[1] + r_sq[2]) <= mvt_pkg::NEAR_ZERO_SQ)};
        end
    end

    // vector length
    logic [RW-1:0] len;

    mvt_sqrt #(
        .ROOT_W (RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r_s),
        .o_root (len)
    );

    mvt_delay #(
        .WIDTH (SIDE_W),
        .DEPTH (RW)
    ) u_side_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_side),
        .o_q   (side_d)
    );

    // rounded quotients |w| * 16384 / len
    logic [RW-1:0]     d_aw [3];
    logic [2:0]        d_sgn;
    logic              d_near;
    logic [RW+13:0]    r_num [3];
    logic [RW-1:0]     r_len;
    logic [2:0]        r_qneg;
    logic              r_zero;
    logic              zero_d;
    logic signed [15:0] unit [3];

    assign d_aw[0] = side_d[SIDE_W-1 -: RW];
    assign d_aw[1] = side_d[SIDE_W-1-RW -: RW];
    assign d_aw[2] = side_d[SIDE_W-1-2*RW -: RW];
    assign d_sgn   = side_d[3:1];
    assign d_near  = side_d[0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_num[a] <= {d_aw[a], 14'd0} + (RW+14)'(len >> 1);
            end
            r_len  <= len;
            r_qneg <= d_sgn;
            r_zero <= d_near || (len == '0);
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_div2
        mvt_div #(
            .NUM_W (RW + 14),
            .DEN_W (RW),
            .QUO_W (QW2),
            .OUT_W (QW2 + 1)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (r_num[a]),
            .i_den (r_len),
            .i_neg (r_qneg[a]),
            .o_quo (unit[a])
        );
    end

    mvt_delay #(
        .WIDTH (1),
        .DEPTH (QW2 + 1)
    ) u_zero_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_zero),
        .o_q   (zero_d)
    );

    assign o_res.norm_x = unit[0];
    assign o_res.norm_y = unit[1];
    assign o_res.norm_z = unit[2];
    assign o_res.zero   = zero_d;

endmodule

`default_nettype wire

// ===== rtl/mesh_vertex_transform.sv =====
// throughput: one item per cycle; the whole pipeline advances together unless a result
//   waits on a stalled output, which freezes every stage and holds o_stall high
// depth is set by the two bit-serial dividers (46 and 15 quotient-bit stages) and the 21-stage root
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// mesh_vertex_transform
// scales, yaws and translates vertices, renormalizes normals, rebases triangles
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_transform #(
    parameter int INDEX_BITS = 24
) (
    input  wire              i_clk,
    input  wire              i_rst_n,

    // item input
    input  wire              i_valid,
    input  wire mvt_pkg::t_in i_data,
    output logic             o_stall,

    // result output
    output logic             o_valid,
    output mvt_pkg::t_out    o_data,
    input  wire              i_stall,

    // register port
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [4:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NLAT = mvt_pkg::NORM_LAT;
    localparam int LAST = NLAT + 1;
    // largest corner index allowed after rebasing
    localparam logic [32:0] IDX_LIM = (33'd1 << INDEX_BITS) - 33'd1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_trans_x, r_trans_y, r_trans_z;
    logic [31:0]        r_rotation;
    logic signed [31:0] r_scale_x, r_scale_y, r_scale_z;
    logic [23:0]        r_index_base;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_x    <= '0;
            r_trans_y    <= '0;
            r_trans_z    <= '0;
            r_rotation   <= mvt_pkg::ROT_RESET;
            r_scale_x    <= mvt_pkg::SCALE_RESET;
            r_scale_y    <= mvt_pkg::SCALE_RESET;
            r_scale_z    <= mvt_pkg::SCALE_RESET;
            r_index_base <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                mvt_pkg::REG_TRANS_X:    r_trans_x    <= pwdata;
                mvt_pkg::REG_TRANS_Y:    r_trans_y    <= pwdata;
                mvt_pkg::REG_TRANS_Z:    r_trans_z    <= pwdata;
                mvt_pkg::REG_ROTATION:   r_rotation   <= pwdata;
                mvt_pkg::REG_SCALE_X:    r_scale_x    <= pwdata;
                mvt_pkg::REG_SCALE_Y:    r_scale_y    <= pwdata;
                mvt_pkg::REG_SCALE_Z:    r_scale_z    <= pwdata;
                mvt_pkg::REG_INDEX_BASE: r_index_base <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            mvt_pkg::REG_TRANS_X:    prdata = r_trans_x;
            mvt_pkg::REG_TRANS_Y:    prdata = r_trans_y;
            mvt_pkg::REG_TRANS_Z:    prdata = r_trans_z;
            mvt_pkg::REG_ROTATION:   prdata = r_rotation;
            mvt_pkg::REG_SCALE_X:    prdata = r_scale_x;
            mvt_pkg::REG_SCALE_Y:    prdata = r_scale_y;
            mvt_pkg::REG_SCALE_Z:    prdata = r_scale_z;
            mvt_pkg::REG_INDEX_BASE: prdata = {8'd0, r_index_base};
            default:                 prdata = '0;
        endcase
    end

    // yaw cosine and sine, Q2.14
    logic signed [15:0] rot_cos, rot_sin;
    assign rot_cos = r_rotation[31:16];
    assign rot_sin = r_rotation[15:0];

    // ------------------------------------------------------------------
    // pipeline control: every stage moves on the same enable, so the
    // valid vector below stays aligned with all data stages
    // ------------------------------------------------------------------
    logic            pipe_en;
    logic [LAST:0]   r_vld;

    // freeze only when a finished result is held by the receiver
    assign pipe_en = !(r_vld[LAST] && i_stall);
    assign o_stall = !pipe_en;
    assign o_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    // input register, stage 0
    mvt_pkg::t_in r_in;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_in <= i_data;
        end
    end

    // ------------------------------------------------------------------
    // triangle rebase, done at stage 0 and carried as side data
    // ------------------------------------------------------------------
    logic [24:0]     sum_a, sum_b, sum_c;
    logic            mirrored;
    mvt_pkg::t_side  side_in, side_out;

    assign sum_a    = 25'(r_in.corner_a) + 25'(r_index_base);
    assign sum_b    = 25'(r_in.corner_b) + 25'(r_index_base);
    assign sum_c    = 25'(r_in.corner_c) + 25'(r_index_base);
    // odd count of negative scales flips winding
    assign mirrored = r_scale_x[31] ^ r_scale_y[31] ^ r_scale_z[31];

    assign side_in.req_type = r_in.req_type;
    assign side_in.tex_u    = r_in.tex_u;
    assign side_in.tex_v    = r_in.tex_v;
    assign side_in.tri_ovf  = (33'(sum_a) > IDX_LIM) || (33'(sum_b) > IDX_LIM) ||
                              (33'(sum_c) > IDX_LIM);
    assign side_in.first    = sum_a[23:0];
    assign side_in.second   = mirrored ? sum_c[23:0] : sum_b[23:0];
    assign side_in.third    = mirrored ? sum_b[23:0] : sum_c[23:0];

    mvt_delay #(
        .WIDTH ($bits(mvt_pkg::t_side)),
        .DEPTH (NLAT)
    ) u_side_dly (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (side_in),
        .o_q   (side_out)
    );

    // ------------------------------------------------------------------
    // position path: scale, round, yaw, round, translate, saturate
    // ------------------------------------------------------------------
    logic signed [63:0] r_prod_x, r_prod_y, r_prod_z;
    logic signed [47:0] r_px, r_py, r_pz;
    logic signed [63:0] r_ma, r_mb, r_mc, r_md;
    logic signed [47:0] r_py3;
    logic signed [63:0] r_sx, r_sz;
    logic signed [47:0] r_py4;
    logic signed [50:0] r_x5, r_y5, r_z5;
    logic [95:0]        r_pos6;
    logic [95:0]        pos_d;

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            sat32 = 32'h7fff_ffff;
        end else if (v < -51'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_prod_x <= 64'(r_in.pos_x) * 64'(r_scale_x);
            r_prod_y <= 64'(r_in.pos_y) * 64'(r_scale_y);
            r_prod_z <= 64'(r_in.pos_z) * 64'(r_scale_z);
            // round half up back to Q16.16
            r_px <= 48'((r_prod_x + 64'sd32768) >>> 16);
            r_py <= 48'((r_prod_y + 64'sd32768) >>> 16);
            r_pz <= 48'((r_prod_z + 64'sd32768) >>> 16);
            r_ma  <= 64'(rot_cos) * 64'(r_px);
            r_mb  <= 64'(rot_sin) * 64'(r_pz);
            r_mc  <= 64'(rot_cos) * 64'(r_pz);
            r_md  <= 64'(rot_sin) * 64'(r_px);
            r_py3 <= r_py;
            // rounding bias folded into the sum
            r_sx  <= r_ma + r_mb + 64'sd8192;
            r_sz  <= r_mc - r_md + 64'sd8192;
            r_py4 <= r_py3;
            r_x5  <= 51'(r_sx >>> 14) + 51'(r_trans_x);
            r_y5  <= 51'(r_py4) + 51'(r_trans_y);
            r_z5  <= 51'(r_sz >>> 14) + 51'(r_trans_z);
            r_pos6 <= {sat32(r_x5), sat32(r_y5), sat32(r_z5)};
        end
    end

    mvt_delay #(
        .WIDTH (96),
        .DEPTH (NLAT - mvt_pkg::POS_LAT)
    ) u_pos_dly (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (r_pos6),
        .o_q   (pos_d)
    );

    // ------------------------------------------------------------------
    // normal path
    // ------------------------------------------------------------------
    mvt_pkg::t_nrm nrm;

    mvt_norm u_norm (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_norm_x  (r_in.norm_x),
        .i_norm_y  (r_in.norm_y),
        .i_norm_z  (r_in.norm_z),
        .i_scale_x (r_scale_x),
        .i_scale_y (r_scale_y),
        .i_scale_z (r_scale_z),
        .i_cos     (rot_cos),
        .i_sin     (rot_sin),
        .o_res     (nrm)
    );

    // ------------------------------------------------------------------
    // output register: pick the fields for the item kind
    // ------------------------------------------------------------------
    mvt_pkg::t_out r_out, n_out;
    logic          scale_zero;

    assign scale_zero = (r_scale_x == '0) || (r_scale_y == '0) || (r_scale_z == '0);

    always_comb begin
        n_out = '0;
        if (scale_zero) begin
            n_out.out_kind = mvt_pkg::KIND_REJECT;
        end else if (side_out.req_type == mvt_pkg::REQ_TRI) begin
            if (side_out.tri_ovf) begin
                n_out.out_kind = mvt_pkg::KIND_OVF;
            end else begin
                n_out.out_kind   = mvt_pkg::KIND_TRI;
                n_out.out_first  = side_out.first;
                n_out.out_second = side_out.second;
                n_out.out_third  = side_out.third;
            end
        end else begin
            n_out.out_kind  = mvt_pkg::KIND_VERTEX;
            n_out.out_pos_x = pos_d[95:64];
            n_out.out_pos_y = pos_d[63:32];
            n_out.out_pos_z = pos_d[31:0];
            // near-zero normals come out as zero
            if (!nrm.zero) begin
                n_out.out_norm_x = nrm.norm_x;
                n_out.out_norm_y = nrm.norm_y;
                n_out.out_norm_z = nrm.norm_z;
            end
            n_out.out_u = side_out.tex_u;
            n_out.out_v = side_out.tex_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output was held");

    a_vertex_no_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.out_kind == mvt_pkg::KIND_VERTEX) |->
        (o_data.out_first == '0 && o_data.out_second == '0 && o_data.out_third == '0))
        else $error("vertex result carries corner indices");

    a_tri_no_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.out_kind != mvt_pkg::KIND_VERTEX) |->
        (o_data.out_pos_x == '0 && o_data.out_pos_y == '0 && o_data.out_pos_z == '0 &&
         o_data.out_u == '0 && o_data.out_v == '0))
        else $error("non-vertex result carries vertex data");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.out_kind == mvt_pkg::KIND_VERTEX) |->
        (o_data.out_norm_x <= 16'sd16384 && o_data.out_norm_x >= -16'sd16384 &&
         o_data.out_norm_y <= 16'sd16384 && o_data.out_norm_y >= -16'sd16384 &&
         o_data.out_norm_z <= 16'sd16384 && o_data.out_norm_z >= -16'sd16384))
        else $error("normal component beyond unit length");

endmodule

`default_nettype wire
